// ===== hdl/gsmp_pkg.sv =====
package gsmp_pkg;

  localparam int MaxStops = 8;
  localparam int IdxW     = $clog2(MaxStops);
  localparam int CntW     = $clog2(MaxStops + 1);
  localparam int PosW     = 7;
  localparam int ChanW    = 8;
  localparam int ColorW   = 32;
  localparam int ProdW    = ChanW + PosW;
  localparam int StepW    = $clog2(ChanW);

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpAdd    = 2'd1;
  localparam logic [1:0] OpSample = 2'd2;

  localparam logic [ColorW-1:0] OpaqueBlack = 32'hFF00_0000;
  localparam logic [PosW-1:0]   PctMax      = 7'd100;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [PosW-1:0]   pos;
  } stop_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    stop_t           data;
  } ram_wr_t;

endpackage

// ===== hdl/gsmp_stop_ram.sv =====
module gsmp_stop_ram (
  input  logic                      clk_i,
  input  gsmp_pkg::ram_wr_t         wr_i,
  input  logic [gsmp_pkg::IdxW-1:0] rd_addr_i,
  output gsmp_pkg::stop_t           rd_data_o
);
  import gsmp_pkg::*;

  stop_t mem [MaxStops];
  stop_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/gsmp_div.sv =====
module gsmp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gsmp_pkg::ProdW-1:0] dividend_i,
  input  logic [gsmp_pkg::PosW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [gsmp_pkg::ChanW-1:0] quot_o
);
  import gsmp_pkg::*;

  // restoring divider, one quotient bit per cycle; quotient known to fit ChanW bits
  logic             busy_q, done_q;
  logic [StepW-1:0] cnt_q;
  logic [PosW-1:0]  rem_q, rem_d;
  logic [ChanW-1:0] dvd_q, dvd_d;
  logic [PosW:0]    trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, dvd_q[ChanW-1]};
    ge    = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
    rem_d = ge ? diff[PosW-1:0] : trial[PosW-1:0];
    dvd_d = {dvd_q[ChanW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + StepW'(1);
        if (cnt_q == StepW'(ChanW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[ProdW-1 -: PosW];
      dvd_q <= dividend_i[ChanW-1:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ===== hdl/multi_stop_gradient_sampler_core.sv =====
// Multi-stop gradient sampler: keeps up to MaxStops position-sorted color stops and handles
// one operation per item (clear, add stop, sample). Every item yields one result item.
// The block takes one item at a time and drops s_axis_tready while it works; a finished
// result sits in the output register, so the next item is taken while it waits. Clear and
// the unused opcode go straight to the output state. Add walks the stop memory from the top,
// moving each stop with a greater position up one slot. Sample reads the first and last
// stop, then scans one stop per cycle to the bracketing pair, then runs each of the four
// channels through the multiply state and the shared divider, then the output state.
module multi_stop_gradient_sampler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[7:0], stop_color[39:8]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // sampled_color[31:0]
  output logic [0:0]  m_axis_tuser   // status[0]
);
  import gsmp_pkg::*;

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SInsChk  = 4'd1;
  localparam logic [3:0] SInsCmp  = 4'd2;
  localparam logic [3:0] SSmpChk0 = 4'd3;
  localparam logic [3:0] SSmpChkL = 4'd4;
  localparam logic [3:0] SScan    = 4'd5;
  localparam logic [3:0] SMul     = 4'd6;
  localparam logic [3:0] SDivGo   = 4'd7;
  localparam logic [3:0] SDivWait = 4'd8;
  localparam logic [3:0] SOut     = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [CntW-1:0]   total_q, total_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [1:0]        ch_q, ch_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ColorW-1:0] color_q, color_d;
  stop_t             prev_q, prev_d, hi_q, hi_d;
  logic [PosW-1:0]   span_q, span_d, off_q, off_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic              neg_q, neg_d;
  logic [ColorW-1:0] res_q, res_d;
  logic              status_q, status_d;
  logic              out_valid_q;
  logic [ColorW-1:0] out_color_q;
  logic              out_status_q;

  ram_wr_t           ram_wr;
  logic [IdxW-1:0]   rd_addr;
  stop_t             rd_data;
  logic              div_start, div_done;
  logic [ChanW-1:0]  div_quot;

  logic              s_acc;
  logic signed [7:0] in_pos;
  logic [PosW-1:0]   in_pos_clamped;
  logic [CntW-1:0]   total_m1;
  logic [ChanW-1:0]  chan_a, chan_b, mag, chan_res;
  logic [ChanW:0]    diff, diff_neg;

  assign s_axis_tready = (state_q == SIdle);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_pos        = $signed(s_axis_tdata[7:0]);
  assign total_m1      = total_q - CntW'(1);

  always_comb begin
    if (in_pos[7]) begin
      in_pos_clamped = '0;
    end else if (in_pos[6:0] > PctMax) begin
      in_pos_clamped = PctMax;
    end else begin
      in_pos_clamped = in_pos[6:0];
    end
  end

  always_comb begin
    chan_a   = prev_q.color[ch_q*ChanW +: ChanW];
    chan_b   = hi_q.color[ch_q*ChanW +: ChanW];
    diff     = {1'b0, chan_b} - {1'b0, chan_a};
    diff_neg = -diff;
    mag      = diff[ChanW] ? diff_neg[ChanW-1:0] : diff[ChanW-1:0];
    chan_res = neg_q ? chan_a - div_quot : chan_a + div_quot;
  end

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    idx_d     = idx_q;
    ch_d      = ch_q;
    pos_d     = pos_q;
    color_d   = color_q;
    prev_d    = prev_q;
    hi_d      = hi_q;
    span_d    = span_q;
    off_d     = off_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    res_d     = res_q;
    status_d  = status_q;
    ram_wr    = '0;
    rd_addr   = '0;
    div_start = 1'b0;
    case (state_q)
      SIdle: begin
        if (s_acc) begin
          pos_d    = in_pos_clamped;
          color_d  = s_axis_tdata[39:8];
          res_d    = '0;
          status_d = 1'b0;
          state_d  = SOut;
          case (s_axis_tuser)
            OpClear: begin
              total_d = '0;
            end
            OpAdd: begin
              if (total_q >= CntW'(MaxStops)) begin
                status_d = 1'b1;
              end else begin
                idx_d   = total_q[IdxW-1:0];
                total_d = total_q + CntW'(1);
                state_d = SInsChk;
              end
            end
            OpSample: begin
              if (total_q == '0) begin
                res_d = OpaqueBlack;
              end else begin
                state_d = SSmpChk0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SInsChk: begin
        if (idx_q == '0) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = idx_q;
          ram_wr.data = '{color: color_q, pos: pos_q};
          state_d     = SOut;
        end else begin
          rd_addr = idx_q - IdxW'(1);
          state_d = SInsCmp;
        end
      end
      SInsCmp: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = idx_q;
        if (rd_data.pos > pos_q) begin
          ram_wr.data = rd_data;
          idx_d       = idx_q - IdxW'(1);
          state_d     = SInsChk;
        end else begin
          ram_wr.data = '{color: color_q, pos: pos_q};
          state_d     = SOut;
        end
      end
      SSmpChk0: begin
        if (total_q == CntW'(1) || pos_q <= rd_data.pos) begin
          res_d   = rd_data.color;
          state_d = SOut;
        end else begin
          prev_d  = rd_data;
          rd_addr = total_m1[IdxW-1:0];
          state_d = SSmpChkL;
        end
      end
      SSmpChkL: begin
        if (pos_q >= rd_data.pos) begin
          res_d   = rd_data.color;
          state_d = SOut;
        end else begin
          idx_d   = IdxW'(1);
          rd_addr = IdxW'(1);
          state_d = SScan;
        end
      end
      SScan: begin
        if (rd_data.pos >= pos_q) begin
          hi_d   = rd_data;
          span_d = rd_data.pos - prev_q.pos;
          off_d  = pos_q - prev_q.pos;
          ch_d   = '0;
          if (rd_data.pos == prev_q.pos) begin
            res_d   = prev_q.color;
            state_d = SOut;
          end else begin
            state_d = SMul;
          end
        end else begin
          prev_d  = rd_data;
          idx_d   = idx_q + IdxW'(1);
          rd_addr = idx_q + IdxW'(1);
        end
      end
      SMul: begin
        prod_d  = {{PosW{1'b0}}, mag} * {{ChanW{1'b0}}, off_q};
        neg_d   = diff[ChanW];
        state_d = SDivGo;
      end
      SDivGo: begin
        div_start = 1'b1;
        state_d   = SDivWait;
      end
      SDivWait: begin
        if (div_done) begin
          res_d[ch_q*ChanW +: ChanW] = chan_res;
          ch_d = ch_q + 2'd1;
          state_d = (ch_q == 2'd3) ? SOut : SMul;
        end
      end
      SOut: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (state_q == SOut && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ch_q     <= ch_d;
    pos_q    <= pos_d;
    color_q  <= color_d;
    prev_q   <= prev_d;
    hi_q     <= hi_d;
    span_q   <= span_d;
    off_q    <= off_d;
    prod_q   <= prod_d;
    neg_q    <= neg_d;
    res_q    <= res_d;
    status_q <= status_d;
    if (state_q == SOut && (!out_valid_q || m_axis_tready)) begin
      out_color_q  <= res_q;
      out_status_q <= status_q;
    end
  end

  gsmp_stop_ram u_stop_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gsmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_color_q;
  assign m_axis_tuser  = out_status_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(MaxStops))
    else $error("stop count beyond table depth");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SScan |-> {1'b0, idx_q} < total_q)
    else $error("segment scan past last stop");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == SDivWait)
    else $error("divider finished outside wait state");

  a_full_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == OpAdd && total_q == CntW'(MaxStops)
    |=> state_q == SOut && status_q && $stable(total_q))
    else $error("add into full table changed state");

endmodule

// ===== tb/sv/gsmp_checker.sv =====
module gsmp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,  // position[7:0], stop_color[39:8]
  input  logic [1:0]  s_axis_tuser_i,  // opcode[1:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,  // sampled_color[31:0]
  input  logic [0:0]  m_axis_tuser_i,  // status[0]
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsmp_pkg::*;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              status;
  } outcome_t;

  logic [PosW-1:0]   stop_pos_q   [MaxStops];
  logic [ColorW-1:0] stop_color_q [MaxStops];
  int                live_stops;
  outcome_t          outcome_q [$];
  int                fails;

  assign fail_count_o = fails;

  function automatic int clamp_pct(logic signed [7:0] raw);
    int v;
    v = raw;
    if (v < 0) return 0;
    if (v > int'(PctMax)) return int'(PctMax);
    return v;
  endfunction

  function automatic logic [ChanW-1:0] blend_channel(logic [ChanW-1:0] lo_c,
                                                     logic [ChanW-1:0] hi_c,
                                                     int off, int span);
    int a;
    int b;
    a = lo_c;
    b = hi_c;
    if (span <= 0) return lo_c;
    return ChanW'(a + ((b - a) * off) / span);
  endfunction

  function automatic logic [ColorW-1:0] gradient_at(int pos);
    int lo;
    int hi;
    int span;
    int off;
    bit found;
    logic [ColorW-1:0] res;
    if (live_stops == 0) return OpaqueBlack;
    hi = live_stops - 1;
    if (live_stops == 1 || pos <= int'(stop_pos_q[0])) return stop_color_q[0];
    if (pos >= int'(stop_pos_q[hi])) return stop_color_q[hi];
    lo = 0;
    found = 1'b0;
    for (int i = 0; i + 1 < live_stops; i++) begin
      if (!found && pos >= int'(stop_pos_q[i]) && pos <= int'(stop_pos_q[i+1])) begin
        lo = i;
        hi = i + 1;
        found = 1'b1;
      end
    end
    span = int'(stop_pos_q[hi]) - int'(stop_pos_q[lo]);
    off  = pos - int'(stop_pos_q[lo]);
    res  = '0;
    for (int c = 0; c < ColorW / ChanW; c++) begin
      res[c*ChanW +: ChanW] = blend_channel(stop_color_q[lo][c*ChanW +: ChanW],
                                            stop_color_q[hi][c*ChanW +: ChanW], off, span);
    end
    return res;
  endfunction

  // stable insert: new stop lands after any stop at the same position
  function automatic bit store_stop(int pos, logic [ColorW-1:0] color);
    int i;
    if (live_stops >= MaxStops) return 1'b0;
    i = live_stops;
    live_stops++;
    while (i > 0 && int'(stop_pos_q[i-1]) > pos) begin
      stop_pos_q[i]   = stop_pos_q[i-1];
      stop_color_q[i] = stop_color_q[i-1];
      i--;
    end
    stop_pos_q[i]   = PosW'(pos);
    stop_color_q[i] = color;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    int pos;
    if (!rst_ni) begin
      live_stops = 0;
      outcome_q.delete();
      fails = 0;
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pos  = clamp_pct(s_axis_tdata_i[7:0]);
        want = '0;
        case (s_axis_tuser_i)
          OpClear: begin
            live_stops = 0;
          end
          OpAdd: begin
            want.status = !store_stop(pos, s_axis_tdata_i[39:8]);
          end
          OpSample: begin
            want.color = gradient_at(pos);
          end
          default: ;
        endcase
        outcome_q.push_back(want);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result item: sampled_color %h status %b",
                 m_axis_tdata_i, m_axis_tuser_i[0]);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tdata_i !== want.color) begin
            $error("sampled_color mismatch: expected %h, actual %h", want.color,
                   m_axis_tdata_i);
            fails++;
          end
          if (m_axis_tuser_i[0] !== want.status) begin
            $error("status mismatch: expected %b, actual %b", want.status,
                   m_axis_tuser_i[0]);
            fails++;
          end
        end
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gsmp_pkg::*;

  localparam logic [1:0] OpReserved   = 2'd3;
  localparam int         RandomItems  = 850;
  localparam int         IdleLimit    = 2000;
  localparam int         TailCycles   = 64;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = OpClear;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int fail_count;
  int pending;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;
  int stall_mode = 0;

  logic [7:0] hot_pos [5] = '{8'd0, 8'd10, 8'd50, 8'd90, 8'd100};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  multi_stop_gradient_sampler_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  gsmp_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // receiver: switches between always ready, coin flip and a sparse periodic pattern
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (rx_cycle % 7) < 2;
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic issue_item(input logic [1:0] op, input logic [7:0] pos,
                            input logic [31:0] color);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {color, pos};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int r;
    logic [1:0] op;
    logic [7:0] pos;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_item(OpSample, 8'd50, 32'h0);
    issue_item(OpReserved, 8'h7F, 32'hFFFF_FFFF);
    issue_item(OpAdd, 8'h7F, 32'h00FF_00FF);
    issue_item(OpAdd, 8'h80, 32'hFF00_FF00);
    issue_item(OpSample, 8'd0, 32'h0);
    issue_item(OpSample, 8'hFF, 32'h0);
    issue_item(OpSample, 8'd100, 32'h0);
    issue_item(OpSample, 8'h7F, 32'h0);
    issue_item(OpSample, 8'd50, 32'h0);
    issue_item(OpSample, 8'd1, 32'h0);
    issue_item(OpAdd, 8'd50, 32'h8080_8080);
    issue_item(OpAdd, 8'd50, 32'h1234_5678);
    issue_item(OpSample, 8'd50, 32'h0);
    issue_item(OpSample, 8'd75, 32'h0);
    issue_item(OpAdd, 8'd25, 32'hDEAD_BEEF);
    issue_item(OpAdd, 8'd75, 32'h0000_0000);
    issue_item(OpAdd, 8'd101, 32'hFFFF_FFFF);
    issue_item(OpAdd, 8'd63, 32'hA5A5_5A5A);
    issue_item(OpAdd, 8'd10, 32'h5A5A_A5A5);
    issue_item(OpSample, 8'd60, 32'h0);
    issue_item(OpClear, 8'd0, 32'hFFFF_FFFF);
    issue_item(OpSample, 8'd30, 32'h0);
    issue_item(OpAdd, 8'd40, 32'h0102_0304);
    issue_item(OpSample, 8'd10, 32'h0);
    issue_item(OpSample, 8'd90, 32'h0);
    drain_results();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 5) op = OpClear;
      else if (r < 8) op = OpReserved;
      else if (r < 45) op = OpAdd;
      else op = OpSample;
      r = $urandom_range(0, 99);
      if (r < 20) pos = hot_pos[$urandom_range(0, 4)];
      else if (r < 35) pos = 8'($urandom_range(0, 255));
      else pos = 8'($urandom_range(0, 100));
      issue_item(op, pos, $urandom);
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gsmp_pkg.sv
hdl/gsmp_stop_ram.sv
hdl/gsmp_div.sv
hdl/multi_stop_gradient_sampler_core.sv
tb/sv/gsmp_checker.sv
tb/sv/tb_top.sv
